/* sv/tvws_pkg.sv */
`timescale 1ns / 1ps

package tvws_pkg;

    localparam int DefTableDepth = 1000;
    localparam int DefAvgDepth   = 32;
    localparam int DefQueueDepth = 4;

    localparam int StepW    = 26;
    localparam int AdcW     = 12;
    localparam int DacW     = 12;
    localparam int SineW    = 16;
    localparam int FracW    = 16;
    localparam int OutShift = 17;

    localparam logic [AdcW-1:0] MidLevel = 12'd2048;
    localparam logic [DacW-1:0] MidScale = 12'd2048;

    // Request opcodes as they arrive on the command channel
    localparam logic [1:0] OpTick = 2'd0;
    localparam logic [1:0] OpAdc  = 2'd1;
    localparam logic [1:0] OpStep = 2'd2;

    typedef enum logic [1:0] {
        CmdTick = 2'd0,
        CmdAdc  = 2'd1,
        CmdStep = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   voice;
        logic [StepW-1:0]       step;
        logic [AdcW-1:0]        adc;
    } cmd_t;

    // Fixed-point helpers for building the sine table at elaboration
    localparam longint unsigned Q60One = 64'd1 << 60;

    localparam longint unsigned OddDiv [17] =
        '{64'd1, 64'd3, 64'd5, 64'd7, 64'd9, 64'd11, 64'd13, 64'd15, 64'd17,
          64'd19, 64'd21, 64'd23, 64'd25, 64'd27, 64'd29, 64'd31, 64'd33};

    localparam longint unsigned SeriesDiv [14] =
        '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
          64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702};

    function automatic longint unsigned q60_mul(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // atan(1/5) or atan(1/239) in Q60
    function automatic longint unsigned atan_inv(input logic use239);
        longint unsigned pw;
        longint unsigned sum;
        pw  = use239 ? Q60One / 64'd239 : Q60One / 64'd5;
        sum = pw;
        for (int n = 1; n <= 16; n++) begin
            pw = use239 ? pw / 64'd57121 : pw / 64'd25;
            if (pw != 64'd0) begin
                if (n % 2 == 1)
                    sum = sum - pw / OddDiv[n];
                else
                    sum = sum + pw / OddDiv[n];
            end
        end
        return sum;
    endfunction

    localparam longint unsigned HalfPi = 64'd8 * atan_inv(1'b0) - 64'd2 * atan_inv(1'b1);

endpackage

/* sv/tvws_cmd_if.sv */
`timescale 1ns / 1ps

interface tvws_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        voice;
    logic [25:0] phase_step;
    logic [11:0] adc_sample;

    modport source (output valid, output opcode, output voice, output phase_step,
                    output adc_sample, input ready);
    modport sink   (input valid, input opcode, input voice, input phase_step,
                    input adc_sample, output ready);
endinterface

/* sv/tvws_dac_if.sv */
`timescale 1ns / 1ps

interface tvws_dac_if;
    logic        valid;
    logic        ready;
    logic [11:0] dac_word;

    modport source (output valid, output dac_word, input ready);
    modport sink   (input valid, input dac_word, output ready);
endinterface

/* sv/tvws_front.sv */
`timescale 1ns / 1ps

module tvws_front
    import tvws_pkg::*;
#(
    parameter int TableDepth = DefTableDepth
)
(
    tvws_cmd_if.sink cmd,
    input  logic     full,
    output logic     push,
    output cmd_t     push_cmd
);

    localparam int IdxW   = $clog2(TableDepth);
    localparam int PhaseW = IdxW + FracW;
    localparam int CmpW   = (StepW > PhaseW + 1) ? StepW : PhaseW + 1;
    localparam logic [CmpW-1:0] PhaseLimit = CmpW'(TableDepth) << FracW;

    logic [CmpW-1:0] step_ext;
    logic [CmpW-1:0] step_sat;
    logic            known;

    assign cmd.ready = !full;

    always_comb
    begin
        step_ext = CmpW'(cmd.phase_step);
        // clamp so one wrap per tick always suffices
        step_sat = (step_ext >= PhaseLimit) ? PhaseLimit - 1'b1 : step_ext;

        push_cmd.voice = cmd.voice;
        push_cmd.step  = StepW'(step_sat);
        push_cmd.adc   = cmd.adc_sample;
        push_cmd.kind  = CmdTick;
        known          = 1'b1;
        case (cmd.opcode)
            OpTick:  push_cmd.kind = CmdTick;
            OpAdc:   push_cmd.kind = CmdAdc;
            OpStep:  push_cmd.kind = CmdStep;
            default: known = 1'b0;
        endcase
        // drop unknown requests: accepted, never queued
        push = cmd.valid && !full && known;
    end

endmodule

/* sv/tvws_queue.sv */
`timescale 1ns / 1ps

module tvws_queue
    import tvws_pkg::*;
#(
    parameter int Depth = DefQueueDepth
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

    cmd_t            slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("command queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty command queue");
`endif

endmodule

/* sv/tvws_sine_rom.sv */
`timescale 1ns / 1ps

module tvws_sine_rom
    import tvws_pkg::*;
#(
    parameter int TableDepth = DefTableDepth
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [$clog2(TableDepth)-1:0]     addr_a,
    input  logic [$clog2(TableDepth)-1:0]     addr_b,
    output logic signed [SineW-1:0]           data_a,
    output logic signed [SineW-1:0]           data_b
);

    localparam longint unsigned DepthL = longint'(TableDepth);

    typedef logic signed [SineW-1:0] rom_t [TableDepth];

    // 32767*sin(2*pi*i/depth), truncated toward zero, from a Q60 Taylor series
    function automatic logic signed [SineW-1:0] sine_entry(input int unsigned i);
        longint unsigned p;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned mag;
        logic            neg;
        p   = longint'(i) * 64'd4;
        neg = 1'b0;
        if (p >= 64'd2 * DepthL)
        begin
            p   = p - 64'd2 * DepthL;
            neg = 1'b1;
        end
        if (p > DepthL)
            p = 64'd2 * DepthL - p;
        if (p == 64'd0)
            return '0;
        if (p == DepthL)
            return neg ? -16'sd32767 : 16'sd32767;
        theta = (HalfPi / DepthL) * p + ((HalfPi % DepthL) * p) / DepthL;
        t2    = q60_mul(theta, theta);
        term  = theta;
        sum   = theta;
        for (int k = 1; k <= 13; k++)
        begin
            term = q60_mul(term, t2) / SeriesDiv[k];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        mag = ((sum >> 30) * 64'd32767 + (((sum & 64'h3FFF_FFFF) * 64'd32767) >> 30)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return neg ? -$signed(SineW'(mag)) : $signed(SineW'(mag));
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TableDepth; i++)
        begin
            r[i] = sine_entry(i);
        end
        return r;
    endfunction

    localparam rom_t SineRom = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= SineRom[addr_a];
            data_b <= SineRom[addr_b];
        end
    end

endmodule

/* sv/tvws_back.sv */
`timescale 1ns / 1ps

module tvws_back
    import tvws_pkg::*;
#(
    parameter int TableDepth = DefTableDepth,
    parameter int AvgDepth   = DefAvgDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    tvws_dac_if.source dac
);

    localparam int IdxW       = $clog2(TableDepth);
    localparam int PhaseW     = IdxW + FracW;
    localparam int CmpW       = (StepW > PhaseW + 1) ? StepW : PhaseW + 1;
    localparam logic [CmpW-1:0] PhaseLimit = CmpW'(TableDepth) << FracW;

    localparam int PosW       = $clog2(AvgDepth);
    localparam int SumW       = AdcW + PosW;
    localparam int RecipShift = SumW + PosW;
    localparam int RecipW     = SumW + 1;
    localparam int LvlProdW   = SumW + RecipW;
    localparam longint unsigned RecipL =
        ((64'd1 << RecipShift) + longint'(AvgDepth) - 64'd1) / longint'(AvgDepth);
    localparam logic [RecipW-1:0] Recip   = RecipW'(RecipL);
    localparam logic [PosW-1:0]   LastPos = PosW'(AvgDepth - 1);
    localparam logic [SumW-1:0]   MaxSum  = SumW'(AvgDepth * (2 ** AdcW - 1));

    localparam int MixW  = SineW + 1;
    localparam int ProdW = MixW + AdcW + 1;

    // voice and volume state
    logic [PhaseW-1:0] phase_a_reg, phase_a_next;
    logic [PhaseW-1:0] phase_b_reg, phase_b_next;
    logic [PhaseW-1:0] step_a_reg,  step_a_next;
    logic [PhaseW-1:0] step_b_reg,  step_b_next;
    logic [SumW-1:0]   sum_reg,     sum_next;
    logic [PosW-1:0]   pos_reg,     pos_next;
    logic              wrapped_reg, wrapped_next;
    logic              seen_reg,    seen_next;

    logic [AdcW-1:0]   ring_mem [AvgDepth];
    logic [AdcW-1:0]   old_q;
    logic [AdcW-1:0]   old_val;
    logic              ring_we;

    // tick pipeline
    logic              adv;
    logic              tick;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    logic              dac_valid_reg;
    logic [SumW-1:0]   s1_sum_reg;
    logic              s1_seen_reg;
    logic signed [SineW-1:0] rom_a;
    logic signed [SineW-1:0] rom_b;
    logic [LvlProdW-1:0]     lvl_prod;
    logic [AdcW-1:0]         level_calc;
    logic [AdcW-1:0]         level_s2_reg;
    logic signed [MixW-1:0]  mix_s2_reg;
    logic signed [ProdW-1:0] mix_ext;
    logic signed [ProdW-1:0] lvl_ext;
    logic signed [ProdW-1:0] prod_calc;
    logic signed [ProdW-1:0] prod_s3_reg;
    logic signed [ProdW-1:0] shifted;
    logic [DacW-1:0]         dac_word_reg;

    function automatic logic [PhaseW-1:0] advance(input logic [PhaseW-1:0] ph,
                                                  input logic [PhaseW-1:0] st);
        logic [CmpW-1:0] acc;
        acc = CmpW'(ph) + CmpW'(st);
        if (acc >= PhaseLimit)
            acc = acc - PhaseLimit;
        return acc[PhaseW-1:0];
    endfunction

    // the whole back end freezes while a finished word waits
    assign adv       = !dac_valid_reg || dac.ready;
    assign pop       = head_valid && adv;
    assign tick      = pop && (head.kind == CmdTick);
    assign ring_we   = pop && (head.kind == CmdAdc);
    assign old_val   = wrapped_reg ? old_q : '0;
    assign dac.valid = dac_valid_reg;
    assign dac.dac_word = dac_word_reg;

    always_comb
    begin
        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        step_a_next  = step_a_reg;
        step_b_next  = step_b_reg;
        sum_next     = sum_reg;
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        seen_next    = seen_reg;
        if (pop)
        begin
            case (head.kind)
                CmdTick:
                begin
                    phase_a_next = advance(phase_a_reg, step_a_reg);
                    phase_b_next = advance(phase_b_reg, step_b_reg);
                end
                CmdAdc:
                begin
                    // slots not yet filled since reset count as zero
                    sum_next     = sum_reg - SumW'(old_val) + SumW'(head.adc);
                    pos_next     = (pos_reg == LastPos) ? '0 : pos_reg + 1'b1;
                    wrapped_next = wrapped_reg || (pos_reg == LastPos);
                    seen_next    = 1'b1;
                end
                CmdStep:
                begin
                    if (!head.voice)
                    begin
                        step_a_next = PhaseW'(head.step);
                        if (head.step == '0)
                            phase_a_next = '0;
                    end
                    else
                    begin
                        step_b_next = PhaseW'(head.step);
                        if (head.step == '0)
                            phase_b_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_a_reg   <= '0;
            phase_b_reg   <= '0;
            step_a_reg    <= '0;
            step_b_reg    <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            dac_valid_reg <= 1'b0;
        end
        else
        begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
            step_a_reg  <= step_a_next;
            step_b_reg  <= step_b_next;
            sum_reg     <= sum_next;
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            seen_reg    <= seen_next;
            if (adv)
            begin
                s1_valid_reg  <= tick;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                dac_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ring of volume readings; prefetch the slot the next reading replaces
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= head.adc;
        end
        old_q <= ring_mem[pos_next];
    end

    tvws_sine_rom #(
        .TableDepth (TableDepth)
    ) u_rom (
        .clk    (clk),
        .en     (adv),
        .addr_a (phase_a_next[PhaseW-1:FracW]),
        .addr_b (phase_b_next[PhaseW-1:FracW]),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    always_comb
    begin
        lvl_prod   = LvlProdW'(s1_sum_reg) * LvlProdW'(Recip);
        level_calc = s1_seen_reg ? lvl_prod[RecipShift +: AdcW] : MidLevel;
        mix_ext    = mix_s2_reg;
        lvl_ext    = $signed(ProdW'(level_s2_reg));
        prod_calc  = mix_ext * lvl_ext;
        shifted    = prod_s3_reg >>> OutShift;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // snapshot the sum so later volume requests do not leak in
            s1_sum_reg   <= sum_reg;
            s1_seen_reg  <= seen_reg;
            level_s2_reg <= level_calc;
            mix_s2_reg   <= MixW'(rom_a) + MixW'(rom_b);
            prod_s3_reg  <= prod_calc;
            dac_word_reg <= shifted[DacW-1:0] + MidScale;
        end
    end

`ifndef ASSERT_OFF
    a_phase_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        CmpW'(phase_a_reg) < PhaseLimit)
        else $error("voice a phase beyond table");
    a_phase_b_range: assert property (@(posedge clk) disable iff (!rst_n)
        CmpW'(phase_b_reg) < PhaseLimit)
        else $error("voice b phase beyond table");
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= MaxSum)
        else $error("volume sum beyond ring capacity");
    a_zero_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == CmdStep && !head.voice && head.step == '0)
        |=> (phase_a_reg == '0 && step_a_reg == '0))
        else $error("zero step did not clear voice a");
`endif

endmodule

/* sv/two_voice_wavetable_synth_volume.sv */
`timescale 1ns / 1ps

// Channel | Role   | Handshake   | Payload
// cmd     | sink   | valid/ready | opcode, voice, phase_step, adc_sample
// dac     | source | valid/ready | dac_word
//
// One request per cycle is taken while the command queue has room.
// A tick passes these registered steps before its DAC word appears:
// queue, phase update with the registered sine ROM read, mix, volume scale and offset.
// Reset clears state except data words; volume reads midscale until the first reading.
// A DAC word held by low dac.ready freezes the back end; the queue then holds
// QueueDepth requests before cmd.ready drops. Unknown opcodes are taken and dropped.
module two_voice_wavetable_synth_volume
    import tvws_pkg::*;
#(
    parameter int TableDepth = DefTableDepth,
    parameter int AvgDepth   = DefAvgDepth,
    parameter int QueueDepth = DefQueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    tvws_cmd_if.sink   cmd,
    tvws_dac_if.source dac
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic head_valid;
    cmd_t head;
    logic pop;

    tvws_front #(
        .TableDepth (TableDepth)
    ) u_front (
        .cmd      (cmd),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tvws_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tvws_back #(
        .TableDepth (TableDepth),
        .AvgDepth   (AvgDepth)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dac        (dac)
    );

endmodule
